@@ sv/clfqp_pkg.sv @@
package clfqp_pkg;

  localparam int RATE_W    = 16;
  localparam int LIMIT_W   = 15;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'd1;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd4096;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd4096;

  typedef logic [1:0] status_t;

  localparam status_t ST_MET     = 2'd0;
  localparam status_t ST_NOAUTH  = 2'd1;
  localparam status_t ST_SOLVED  = 2'd2;
  localparam status_t ST_CLAMPED = 2'd3;

  typedef struct packed {
    logic met;
    logic noauth;
    logic vneg;
  } side_t;

  // width of the decay sum 2^(f+1)*p*v + c*(p^2+v^2)
  function automatic int sum_bits(input int w, input int f);
    int a;
    int b;
    a = 2 * w + f + 2;
    b = 2 * w + RATE_W + 2;
    return (a > b) ? a : b;
  endfunction

  // width of the positive sum after dropping the f+1 low bits
  function automatic int num_bits(input int w, input int f);
    return sum_bits(w, f) - 2 - f;
  endfunction

endpackage

@@ sv/clf_qp_control_law.sv @@
// the quotient width, and so the number of divider cells, is
// NUMW = max(2*WORD_BITS+FRAC_BITS+2, 2*WORD_BITS+18) - 2 - FRAC_BITS (36 at defaults)
// throughput: one item per cycle; four multiply/sum stages, one divider cell per
// quotient bit and an output register, every stage moves on its own valid/stall
// reset: synchronous active-low, empties all stages, rate and limit return to 1.0
module clf_qp_control_law
  import clfqp_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] in_position,
  input  logic signed [WORD_BITS-1:0] in_velocity,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_drive,
  output status_t                     out_status,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  localparam int W    = WORD_BITS;
  localparam int NUMW = num_bits(WORD_BITS, FRAC_BITS);

  logic [RATE_W-1:0]  rate_r;
  logic [LIMIT_W-1:0] limit_r;

  logic            cv   [NUMW+1];
  logic            cs   [NUMW+1];
  logic [W-1:0]    crem [NUMW+1];
  logic [NUMW-1:0] cnq  [NUMW+1];
  logic [W-1:0]    cdvs [NUMW+1];
  side_t           cside[NUMW+1];

  logic                out_valid_r;
  logic signed [W-1:0] drive_r;
  status_t             status_r;
  logic [W-1:0]        drive_nxt;
  status_t             status_nxt;
  logic                out_hold;

  logic [NUMW-1:0]     q;
  logic [NUMW-1:0]     lim_ext;
  logic                over;
  logic [NUMW-1:0]     mag;
  logic [NUMW-1:0]     mag_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RATE:  rate_r  <= cfg_data[RATE_W-1:0];
        REG_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  clfqp_front #(
    .W (W),
    .F (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .position (in_position),
    .velocity (in_velocity),
    .rate     (rate_r),
    .dn_valid (cv[0]),
    .dn_stall (cs[0]),
    .num      (cnq[0]),
    .dvs      (cdvs[0]),
    .side     (cside[0])
  );

  assign crem[0] = '0;

  for (genvar i = 0; i < NUMW; i++) begin : g_cell
    clfqp_div_cell #(
      .W    (W),
      .NUMW (NUMW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[i]),
      .up_stall (cs[i]),
      .up_rem   (crem[i]),
      .up_nq    (cnq[i]),
      .up_dvs   (cdvs[i]),
      .up_side  (cside[i]),
      .dn_valid (cv[i+1]),
      .dn_stall (cs[i+1]),
      .dn_rem   (crem[i+1]),
      .dn_nq    (cnq[i+1]),
      .dn_dvs   (cdvs[i+1]),
      .dn_side  (cside[i+1])
    );
  end

  assign out_hold = out_valid_r & out_stall;
  assign cs[NUMW] = out_hold;

  assign q       = cnq[NUMW];
  assign lim_ext = NUMW'(limit_r);
  assign over    = q > lim_ext;
  assign mag     = over ? lim_ext : q;
  assign mag_neg = ~mag + 1'b1;

  always_comb begin
    if (cside[NUMW].met) begin
      drive_nxt  = '0;
      status_nxt = ST_MET;
    end else if (cside[NUMW].noauth) begin
      drive_nxt  = '0;
      status_nxt = ST_NOAUTH;
    end else begin
      drive_nxt  = cside[NUMW].vneg ? mag[W-1:0] : mag_neg[W-1:0];
      status_nxt = over ? ST_CLAMPED : ST_SOLVED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_hold) begin
      out_valid_r <= cv[NUMW];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_hold) begin
      drive_r  <= drive_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_drive  = drive_r;
  assign out_status = status_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid right after reset");

  a_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_MET || status_r == ST_NOAUTH) |-> drive_r == '0)
    else $error("nonzero drive without a solved status");

  a_clamp_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_CLAMPED |->
      (drive_r == W'(limit_r)) || (drive_r == -W'(limit_r)))
    else $error("clamped drive differs from the limit");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cv[NUMW] && !cside[NUMW].met && !cside[NUMW].noauth |-> crem[NUMW] < cdvs[NUMW])
    else $error("divider remainder not below divisor");

endmodule

@@ sv/clfqp_front.sv @@
module clfqp_front
  import clfqp_pkg::*;
#(
  parameter int W = 16,
  parameter int F = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_stall,
  input  logic signed [W-1:0]         position,
  input  logic signed [W-1:0]         velocity,
  input  logic [RATE_W-1:0]           rate,
  output logic                        dn_valid,
  input  logic                        dn_stall,
  output logic [num_bits(W, F)-1:0]   num,
  output logic [W-1:0]                dvs,
  output side_t                       side
);

  localparam int NBITS = sum_bits(W, F);
  localparam int NUMW  = num_bits(W, F);
  localparam int CSQW  = 2 * W + RATE_W;

  logic [3:0] vld_r;
  logic [4:0] stall_s;

  logic signed [2*W-1:0] pp_a_r, vv_a_r, pv_a_r;
  logic signed [W-1:0]   v_a_r;
  logic [2*W-1:0]        sq_b_r;
  logic signed [2*W-1:0] pv_b_r;
  logic signed [W-1:0]   v_b_r;
  logic [CSQW-1:0]       csq_c_r;
  logic signed [2*W-1:0] pv_c_r;
  logic signed [W-1:0]   v_c_r;
  logic [NUMW-1:0]       num_d_r;
  logic [W-1:0]          dvs_d_r;
  side_t                 side_d_r;

  logic signed [2*W-1:0] pp_nxt, vv_nxt, pv_nxt;
  logic [CSQW-1:0]       csq_nxt;
  logic signed [NBITS-1:0] n_sum;
  logic                  n_pos;
  logic [W-1:0]          vabs;

  always_comb begin
    stall_s[4] = dn_stall;
    for (int k = 3; k >= 0; k--) begin
      stall_s[k] = vld_r[k] & stall_s[k+1];
    end
  end
  assign up_stall = stall_s[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (!stall_s[0]) vld_r[0] <= up_valid;
      for (int k = 1; k < 4; k++) begin
        if (!stall_s[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign pp_nxt  = position * position;
  assign vv_nxt  = velocity * velocity;
  assign pv_nxt  = position * velocity;
  assign csq_nxt = rate * sq_b_r;

  assign n_sum = $signed({{(NBITS - CSQW){1'b0}}, csq_c_r})
               + (NBITS'(pv_c_r) <<< (F + 1));
  assign n_pos = !n_sum[NBITS-1] && (n_sum != '0);
  assign vabs  = v_c_r[W-1] ? (~v_c_r + 1'b1) : v_c_r;

  always_ff @(posedge clk) begin
    if (!stall_s[0]) begin
      pp_a_r <= pp_nxt;
      vv_a_r <= vv_nxt;
      pv_a_r <= pv_nxt;
      v_a_r  <= velocity;
    end
    if (!stall_s[1]) begin
      sq_b_r <= pp_a_r + vv_a_r;
      pv_b_r <= pv_a_r;
      v_b_r  <= v_a_r;
    end
    if (!stall_s[2]) begin
      csq_c_r <= csq_nxt;
      pv_c_r  <= pv_b_r;
      v_c_r   <= v_b_r;
    end
    if (!stall_s[3]) begin
      num_d_r         <= n_sum[NBITS-2:F+1];
      dvs_d_r         <= vabs;
      side_d_r.met    <= !n_pos;
      side_d_r.noauth <= n_pos && (v_c_r == '0);
      side_d_r.vneg   <= v_c_r[W-1];
    end
  end

  assign dn_valid = vld_r[3];
  assign num      = num_d_r;
  assign dvs      = dvs_d_r;
  assign side     = side_d_r;

endmodule

@@ sv/clfqp_div_cell.sv @@
module clfqp_div_cell
  import clfqp_pkg::*;
#(
  parameter int W    = 16,
  parameter int NUMW = 36
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_stall,
  input  logic [W-1:0]    up_rem,
  input  logic [NUMW-1:0] up_nq,
  input  logic [W-1:0]    up_dvs,
  input  side_t           up_side,
  output logic            dn_valid,
  input  logic            dn_stall,
  output logic [W-1:0]    dn_rem,
  output logic [NUMW-1:0] dn_nq,
  output logic [W-1:0]    dn_dvs,
  output side_t           dn_side
);

  logic            vld_r;
  logic [W-1:0]    rem_r;
  logic [NUMW-1:0] nq_r;
  logic [W-1:0]    dvs_r;
  side_t           side_r;

  logic [W:0]      trial;
  logic            ge;
  logic [W:0]      diff;
  logic [W-1:0]    rem_nxt;
  logic [NUMW-1:0] nq_nxt;

  assign up_stall = vld_r & dn_stall;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  assign trial   = {up_rem, up_nq[NUMW-1]};
  assign ge      = trial >= {1'b0, up_dvs};
  assign diff    = trial - {1'b0, up_dvs};
  assign rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
  assign nq_nxt  = {up_nq[NUMW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!up_stall) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      rem_r  <= rem_nxt;
      nq_r   <= nq_nxt;
      dvs_r  <= up_dvs;
      side_r <= up_side;
    end
  end

  assign dn_valid = vld_r;
  assign dn_rem   = rem_r;
  assign dn_nq    = nq_r;
  assign dn_dvs   = dvs_r;
  assign dn_side  = side_r;

endmodule
